>>> hdl/mva_pkg.sv
// Shared constants and helpers for the masked vector moving average block.
package mva_pkg;

   // Window and sample geometry
   localparam int WINDOW_DEPTH = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int AXES         = 3;

   // Derived widths
   localparam int SLOT_BITS   = $clog2(WINDOW_DEPTH);
   localparam int COUNT_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_WIDTH   = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
   localparam int ENTRY_WIDTH = AXES * SAMPLE_WIDTH;
   localparam int DIV_CNT_BITS = $clog2(SUM_WIDTH + 1);

   // Invalid code after reset: most negative sample value
   localparam logic [SAMPLE_WIDTH-1:0] RESET_CODE = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;
   typedef logic        [COUNT_BITS-1:0]   count_type;

endpackage

>>> hdl/mva_ifs.sv
// Handshake channel interfaces for request, response and register write items.
interface mva_req_if;
   import mva_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_x;
   sample_type sample_y;
   sample_type sample_z;
   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

interface mva_rsp_if;
   import mva_pkg::*;
   logic       valid;
   logic       ready;
   sample_type mean_x;
   sample_type mean_y;
   sample_type mean_z;
   modport source (output valid, output mean_x, output mean_y, output mean_z,
                   input ready);
   modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                   output ready);
endinterface

interface mva_csr_if;
   import mva_pkg::*;
   logic       valid;
   logic       ready;
   sample_type wdata;
   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

>>> hdl/mva_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mva_divider.sv
// Bit-serial restoring divider: signed window sum by unsigned entry count.
module mva_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mva_pkg::sum_type    dividend,
   input  mva_pkg::count_type  divisor,
   output logic                busy,
   output mva_pkg::sample_type quotient
);
   import mva_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [SUM_WIDTH-1:0]    mag_ff, mag_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   dvs_ff, dvs_in;
   logic [COUNT_BITS:0]     trial;
   logic [COUNT_BITS:0]     diff;
   logic                    fits;
   logic [SUM_WIDTH-1:0]    dividend_u;
   logic [SUM_WIDTH-1:0]    signed_q;

   assign dividend_u = SUM_WIDTH'(dividend);

   // Shift in one dividend bit, try the subtraction
   assign trial = {rem_ff, mag_ff[SUM_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         // Load magnitude and sign of the dividend
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(SUM_WIDTH);
         neg_in  = dividend_u[SUM_WIDTH-1];
         mag_in  = dividend_u[SUM_WIDTH-1] ? (~dividend_u + 1'b1) : dividend_u;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // One quotient bit per cycle, shifted into the magnitude register
         mag_in = {mag_ff[SUM_WIDTH-2:0], fits};
         rem_in = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // Restore the sign, truncating toward zero
   assign signed_q = neg_ff ? (~mag_ff + 1'b1) : mag_ff;
   assign quotient = signed_q[SAMPLE_WIDTH-1:0];
   assign busy     = busy_ff;

endmodule

>>> hdl/masked_vector_moving_average.sv
// Items are handled one at a time: a new item is accepted only in the idle state, once the
// one-entry-per-cycle window scan on the RAM read port and the bit-serial dividers are done.
// A finished result waits in the output register while the next item is accepted.
// Reset: synchronous; slot flags mark every window entry as holding the reset invalid
// code, the write slot returns to zero and the invalid code register returns to -32768.
module masked_vector_moving_average (
   input logic      clock,
   input logic      reset,
   mva_req_if.sink  req_ch,
   mva_rsp_if.source rsp_ch,
   mva_csr_if.sink  csr_ch
);
   import mva_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_GATHER = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SLOT_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic [WINDOW_DEPTH-1:0] filled_ff, filled_in;
   logic                  rd_vld_ff;
   logic                  ent_ok_ff;
   logic                  start_ff, start_in;
   sample_type            code_ff;
   sum_type               sum_ff   [AXES];
   count_type             count_ff [AXES];
   sample_type            mean_ff  [AXES];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load_rsp;

   logic                  req_fire;
   logic [ENTRY_WIDTH-1:0] rd_data;
   sample_type            comp     [AXES];
   sample_type            quot     [AXES];
   logic [AXES-1:0]       div_busy;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // Invalid code register
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= sample_type'(RESET_CODE);
      end else if (csr_ch.valid) begin
         code_ff <= csr_ch.wdata;
      end
   end

   // Window storage
   mva_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (slot_ff),
      .wr_data ({req_ch.sample_z, req_ch.sample_y, req_ch.sample_x}),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      rd_addr_in = rd_addr_ff;
      filled_in  = filled_ff;
      start_in   = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               filled_in[slot_ff] = 1'b1;
               slot_in    = (slot_ff == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               rd_addr_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == SLOT_BITS'(WINDOW_DEPTH - 1)) begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            start_in = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!start_ff && (div_busy == '0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         slot_ff   <= '0;
         filled_ff <= '0;
         start_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         filled_ff <= filled_in;
         start_ff  <= start_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   // Track the flag of the entry being read alongside the RAM data
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      ent_ok_ff  <= filled_ff[rd_addr_ff];
   end

   // Per-axis sum and count of entries that differ from the invalid code
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         comp[a] = ent_ok_ff ? sample_type'(rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH])
                             : sample_type'(RESET_CODE);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         if (req_fire) begin
            sum_ff[a]   <= '0;
            count_ff[a] <= '0;
         end else if (rd_vld_ff && (comp[a] != code_ff)) begin
            sum_ff[a]   <= sum_ff[a] + {{(SUM_WIDTH-SAMPLE_WIDTH){comp[a][SAMPLE_WIDTH-1]}},
                                        comp[a]};
            count_ff[a] <= count_ff[a] + COUNT_BITS'(1);
         end
      end
   end

   // One divider lane per axis
   for (genvar a = 0; a < AXES; a++) begin : g_div
      mva_divider u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (start_ff),
         .dividend (sum_ff[a]),
         .divisor  (count_ff[a]),
         .busy     (div_busy[a]),
         .quotient (quot[a])
      );
   end

   // Output register: hold until taken, report the invalid code for an empty axis
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         for (int a = 0; a < AXES; a++) begin
            mean_ff[a] <= (count_ff[a] == '0) ? code_ff : quot[a];
         end
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.mean_x = mean_ff[0];
   assign rsp_ch.mean_y = mean_ff[1];
   assign rsp_ch.mean_z = mean_ff[2];

endmodule

>>> hdl/mva_checker.sv
// Port-level assertions for the masked vector moving average block, with its bind.
module mva_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mva_pkg::sample_type mean_x,
   input mva_pkg::sample_type mean_y,
   input mva_pkg::sample_type mean_z,
   input logic                csr_valid,
   input logic                csr_ready
);
   import mva_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mean_x) && $stable(mean_y)
                                 && $stable(mean_z))
      else $error("stalled result item changed or dropped");

   // No result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: no new item the cycle after one is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Nothing new appears on the result channel right after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared too early");

   // Register writes are never stalled
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind masked_vector_moving_average mva_checker u_mva_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .mean_x    (rsp_ch.mean_x),
   .mean_y    (rsp_ch.mean_y),
   .mean_z    (rsp_ch.mean_z),
   .csr_valid (csr_ch.valid),
   .csr_ready (csr_ch.ready)
);

>>> bench/tb_masked_vector_moving_average.sv
// Testbench for the masked vector moving average, checked against a local predictor.
module tb_masked_vector_moving_average;
   import mva_pkg::*;

   localparam sample_type SAMPLE_MIN   = sample_type'(RESET_CODE);
   localparam sample_type SAMPLE_MAX   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam int         AXIS_X       = 0;
   localparam int         AXIS_Y       = 1;
   localparam int         AXIS_Z       = 2;
   localparam int         RESET_CYCLES = 11;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         PHASE_ITEMS  = 375;

   typedef struct {
      sample_type x;
      sample_type y;
      sample_type z;
   } mean_vector_type;

   logic clock = 1'b0;
   logic reset;

   mva_req_if req_ch ();
   mva_rsp_if rsp_ch ();
   mva_csr_if csr_ch ();

   masked_vector_moving_average DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Local copy of the window, write slot and invalid code
   sample_type window_copy [WINDOW_DEPTH][AXES];
   int         slot_copy;
   sample_type invalid_now;

   mean_vector_type expected_means [$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;
   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int code_writes     = 0;
   int cycle_count     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mean of one axis over the entries that differ from the current invalid code
   function automatic sample_type axis_mean(int axis);
      longint total;
      int     count;
      total = 0;
      count = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (window_copy[i][axis] != invalid_now) begin
            total += window_copy[i][axis];
            count++;
         end
      end
      if (count == 0)
         return invalid_now;
      return sample_type'(total / count);
   endfunction

   // Write one vector into the ring and form the three means
   function automatic mean_vector_type predict_means(sample_type x, sample_type y,
                                                     sample_type z);
      mean_vector_type means;
      window_copy[slot_copy][AXIS_X] = x;
      window_copy[slot_copy][AXIS_Y] = y;
      window_copy[slot_copy][AXIS_Z] = z;
      slot_copy = (slot_copy == WINDOW_DEPTH - 1) ? 0 : slot_copy + 1;
      means.x = axis_mean(AXIS_X);
      means.y = axis_mean(AXIS_Y);
      means.z = axis_mean(AXIS_Z);
      return means;
   endfunction

   // Random component: often the invalid code or an extreme, sometimes near zero
   function automatic sample_type pick_component();
      int roll;
      roll = $urandom_range(99);
      if (roll < 22)
         return invalid_now;
      if (roll < 34) begin
         case ($urandom_range(3))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return sample_type'(0);
            default: return sample_type'(-1);
         endcase
      end
      if (roll < 55)
         return sample_type'(int'($urandom_range(200)) - 100);
      return sample_type'($urandom);
   endfunction

   // Offer one item after a random gap, hold it until accepted
   task automatic send_vector(sample_type x, sample_type y, sample_type z);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid    = 1'b0;
         req_ch.sample_x = sample_type'($urandom);
         req_ch.sample_y = sample_type'($urandom);
         req_ch.sample_z = sample_type'($urandom);
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.sample_x = x;
      req_ch.sample_y = y;
      req_ch.sample_z = z;
      do @(posedge clock); while (!req_ch.ready);
      expected_means.push_back(predict_means(x, y, z));
      items_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Hold the sender until every pending result has come back
   task automatic wait_results_drained();
      while (expected_means.size() != 0)
         @(negedge clock);
   endtask

   // Register write; callers drain the block first
   task automatic write_invalid_code(sample_type code);
      csr_ch.valid = 1'b1;
      csr_ch.wdata = code;
      do @(posedge clock); while (!csr_ch.ready);
      invalid_now = code;
      code_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
      csr_ch.wdata = sample_type'($urandom);
   endtask

   // Reset code still in use: fully masked axis, truncation of negative means
   task automatic test_empty_axis();
      send_vector(SAMPLE_MIN, SAMPLE_MAX, sample_type'(1));
      send_vector(SAMPLE_MIN, SAMPLE_MIN + sample_type'(1), sample_type'(-2));
      send_vector(SAMPLE_MIN, SAMPLE_MAX, sample_type'(-4));
      send_vector(sample_type'(0), sample_type'(0), sample_type'(0));
   endtask

   // New code: old-code entries now count, new-code entries drop out
   task automatic test_code_change();
      wait_results_drained();
      write_invalid_code(sample_type'(0));
      send_vector(sample_type'(0), sample_type'(0), sample_type'(0));
      send_vector(sample_type'(5), sample_type'(-5), SAMPLE_MAX);
      send_vector(sample_type'(0), sample_type'(-7), sample_type'(0));
   endtask

   // Code at both extremes, window full of extreme samples
   task automatic test_extremes();
      wait_results_drained();
      write_invalid_code(SAMPLE_MAX);
      for (int i = 0; i < WINDOW_DEPTH; i++)
         send_vector(SAMPLE_MIN, SAMPLE_MAX - sample_type'(1), SAMPLE_MAX);
      wait_results_drained();
      write_invalid_code(SAMPLE_MIN);
      send_vector(SAMPLE_MAX, SAMPLE_MIN, sample_type'(7));
      send_vector(sample_type'(-7), sample_type'(7), sample_type'(-1));
      send_vector(SAMPLE_MAX, SAMPLE_MIN, sample_type'(-1));
   endtask

   // Stall the receiver for a long stretch while items keep coming
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 400;
      for (int i = 0; i < 24; i++)
         send_vector(pick_component(), pick_component(), pick_component());
      wait_results_drained();
   endtask

   // Random bursts, some with whole axes forced to the invalid code
   task automatic test_random_phase(int idle_pct, int stall_pct, sample_type code, int count);
      int         sent;
      int         burst_len;
      logic [2:0] dropout_mask;
      sample_type x;
      sample_type y;
      sample_type z;
      sent = 0;
      wait_results_drained();
      write_invalid_code(code);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (sent < count) begin
         burst_len    = $urandom_range(4, 16);
         dropout_mask = ($urandom_range(99) < 30) ? 3'($urandom_range(1, 7)) : 3'b000;
         for (int k = 0; k < burst_len && sent < count; k++) begin
            x = dropout_mask[0] ? invalid_now : pick_component();
            y = dropout_mask[1] ? invalid_now : pick_component();
            z = dropout_mask[2] ? invalid_now : pick_component();
            send_vector(x, y, z);
            sent++;
         end
         // change the code mid-phase now and then, once the block is idle
         if ($urandom_range(99) < 5) begin
            wait_results_drained();
            write_invalid_code(($urandom_range(1) == 0) ? sample_type'($urandom)
                                                        : sample_type'(int'($urandom_range(6)) - 3));
         end
      end
   endtask

   // Receiver ready: long hold-off first, else random stalls
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ch.ready = 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted result with the oldest expected means
   always @(posedge clock) begin
      mean_vector_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_means.size() == 0) begin
            $error("result with no item pending: mean_x %0d mean_y %0d mean_z %0d",
                   rsp_ch.mean_x, rsp_ch.mean_y, rsp_ch.mean_z);
            error_count++;
         end else begin
            want = expected_means.pop_front();
            results_checked++;
            if (rsp_ch.mean_x !== want.x) begin
               $error("mean_x mismatch: expected %0d, got %0d", want.x, rsp_ch.mean_x);
               error_count++;
            end
            if (rsp_ch.mean_y !== want.y) begin
               $error("mean_y mismatch: expected %0d, got %0d", want.y, rsp_ch.mean_y);
               error_count++;
            end
            if (rsp_ch.mean_z !== want.z) begin
               $error("mean_z mismatch: expected %0d, got %0d", want.z, rsp_ch.mean_z);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results pending", cycle_count,
                expected_means.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.sample_z = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.wdata    = '0;
      invalid_now     = SAMPLE_MIN;
      slot_copy       = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++)
         for (int a = 0; a < AXES; a++)
            window_copy[i][a] = SAMPLE_MIN;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_axis();
      test_code_change();
      test_extremes();
      test_backpressure();
      test_random_phase(0, 0, sample_type'($urandom), PHASE_ITEMS);
      test_random_phase(71, 0, SAMPLE_MAX, PHASE_ITEMS);
      test_random_phase(0, 71, sample_type'(0), PHASE_ITEMS);
      test_random_phase(28, 28, SAMPLE_MIN, PHASE_ITEMS);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d items, checked %0d results, %0d invalid-code writes.",
               items_sent, results_checked, code_writes);
      $display("Covered empty axes, code changes, extremes, long back-pressure and idle mixes.");
      if (error_count == 0 && expected_means.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
